[rtl/bsoc_pkg.sv]
// Shared types and constants for the barometer second-order compensation block.
// Depends on nothing; used by barometer_second_order_compensation.
`default_nettype none

package bsoc_pkg;

    localparam int NUM_STAGES = 10;

    typedef enum logic [2:0] {
        CFG_SENS        = 3'd0,
        CFG_OFFSET      = 3'd1,
        CFG_SENS_TEMP   = 3'd2,
        CFG_OFFSET_TEMP = 3'd3,
        CFG_REF_TEMP    = 3'd4,
        CFG_TEMP_SLOPE  = 3'd5
    } t_cfg_idx;

    localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [18:0] TEMP_COLD = -19'sd1500;

    localparam logic signed [19:0] TEMP_MIN = -20'sd4000;
    localparam logic signed [19:0] TEMP_MAX = 20'sd8500;
    localparam logic signed [28:0] PRES_MIN = 29'sd1000;
    localparam logic signed [28:0] PRES_MAX = 29'sd120000;

endpackage

`default_nettype wire

[rtl/barometer_second_order_compensation.sv]
// Top level: second-order compensated temperature and pressure from raw readings.
// Ten-stage pipeline; calibration registers written through the cfg port.
// Depends on bsoc_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------------
//  input   | in        | i_valid / o_stall       | i_pressure_raw, i_temperature_raw
//  result  | out       | o_valid / i_stall       | o_temperature_centi, o_pressure_pa, o_clipped
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One request per cycle while o_stall is low; each result passes through the ten register stages.
// The widest step is the split 24 x 40 bit multiply of the raw pressure by the
// corrected sensitivity.
// Synchronous active-low reset clears the stage valid bits and the calibration words.
// Each stage holds while the one after it is full and held; empty stages fill in.
`default_nettype none

module barometer_second_order_compensation (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [23:0]        i_pressure_raw,
    input  wire logic [23:0]        i_temperature_raw,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [14:0]      o_temperature_centi,
    output logic [16:0]             o_pressure_pa,
    output logic                    o_clipped,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    localparam int N = bsoc_pkg::NUM_STAGES;

    logic [15:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    logic [N-1:0] r_vld;
    logic [N-1:0] en;

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (bsoc_pkg::t_cfg_idx'(i_cfg_index))
                bsoc_pkg::CFG_SENS:        r_c1 <= i_cfg_data;
                bsoc_pkg::CFG_OFFSET:      r_c2 <= i_cfg_data;
                bsoc_pkg::CFG_SENS_TEMP:   r_c3 <= i_cfg_data;
                bsoc_pkg::CFG_OFFSET_TEMP: r_c4 <= i_cfg_data;
                bsoc_pkg::CFG_REF_TEMP:    r_c5 <= i_cfg_data;
                bsoc_pkg::CFG_TEMP_SLOPE:  r_c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when the next one loads
    always_comb begin
        en[N-1] = !r_vld[N-1] || !i_stall;
        for (int k = N - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 1: dT
    logic [23:0]        r1_d1;
    logic signed [24:0] r1_dt;
    logic signed [24:0] n1_dt;

    assign n1_dt = $signed({1'b0, i_temperature_raw}) - $signed({1'b0, r_c5, 8'h00});

    // stage 2: products on dT
    logic [23:0]        r2_d1;
    logic signed [41:0] r2_pt, r2_po, r2_ps;
    logic [47:0]        r2_pdd;
    logic signed [41:0] n2_pt, n2_po, n2_ps;
    logic signed [49:0] n2_pdd;

    assign n2_pt  = r1_dt * $signed({1'b0, r_c6});
    assign n2_po  = r1_dt * $signed({1'b0, r_c4});
    assign n2_ps  = r1_dt * $signed({1'b0, r_c3});
    assign n2_pdd = r1_dt * r1_dt;

    // stage 3: TEMP, OFF, SENS, T2 (truncating shifts)
    logic [23:0]        r3_d1;
    logic signed [18:0] r3_temp;
    logic signed [35:0] r3_off, r3_sens;
    logic [16:0]        r3_t2;
    logic signed [41:0] n3_tq, n3_oq, n3_sq;
    logic signed [18:0] n3_temp;
    logic signed [35:0] n3_off, n3_sens;

    assign n3_tq = (r2_pt + (r2_pt[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
    assign n3_oq = (r2_po + (r2_po[41] ? 42'sd127 : 42'sd0)) >>> 7;
    assign n3_sq = (r2_ps + (r2_ps[41] ? 42'sd255 : 42'sd0)) >>> 8;
    assign n3_temp = bsoc_pkg::TEMP_REF + $signed(n3_tq[18:0]);
    assign n3_off  = $signed({4'b0, r_c2, 16'h0000}) + $signed(n3_oq[35:0]);
    assign n3_sens = $signed({5'b0, r_c1, 15'h0000}) + $signed(n3_sq[35:0]);

    // stage 4: squares of the temperature offsets
    logic [23:0]        r4_d1;
    logic signed [18:0] r4_temp;
    logic signed [35:0] r4_off, r4_sens;
    logic [16:0]        r4_t2;
    logic [35:0]        r4_sqa, r4_sqb;
    logic               r4_lt_ref, r4_lt_cold;
    logic signed [18:0] n4_a, n4_b;
    logic signed [37:0] n4_sqa, n4_sqb;

    assign n4_a   = r3_temp - bsoc_pkg::TEMP_REF;
    assign n4_b   = r3_temp - bsoc_pkg::TEMP_COLD;
    assign n4_sqa = n4_a * n4_a;
    assign n4_sqb = n4_b * n4_b;

    // stage 5: OFF2, SENS2, corrected and clamped temperature
    logic [23:0]        r5_d1;
    logic signed [35:0] r5_off, r5_sens;
    logic [37:0]        r5_off2, r5_sens2;
    logic signed [14:0] r5_temp;
    logic               r5_hit;
    logic [39:0]        n5_a5, n5_b7, n5_b11;
    logic [39:0]        n5_off2, n5_sens2;
    logic [16:0]        n5_t2;
    logic signed [19:0] n5_tf;
    logic signed [19:0] n5_tc;
    logic               n5_hit;

    assign n5_a5  = {4'b0, r4_sqa} * 40'd5;
    assign n5_b7  = {4'b0, r4_sqb} * 40'd7;
    assign n5_b11 = {4'b0, r4_sqb} * 40'd11;

    always_comb begin
        n5_off2  = '0;
        n5_sens2 = '0;
        n5_t2    = '0;
        if (r4_lt_ref) begin
            n5_t2    = r4_t2;
            n5_off2  = n5_a5 >> 1;
            n5_sens2 = n5_a5 >> 2;
            if (r4_lt_cold) begin
                n5_off2  = n5_off2 + n5_b7;
                n5_sens2 = n5_sens2 + (n5_b11 >> 1);
            end
        end
    end

    assign n5_tf = $signed({r4_temp[18], r4_temp}) - $signed({3'b0, n5_t2});

    always_comb begin
        n5_tc  = n5_tf;
        n5_hit = 1'b0;
        if (n5_tf < bsoc_pkg::TEMP_MIN) begin
            n5_tc  = bsoc_pkg::TEMP_MIN;
            n5_hit = 1'b1;
        end else if (n5_tf > bsoc_pkg::TEMP_MAX) begin
            n5_tc  = bsoc_pkg::TEMP_MAX;
            n5_hit = 1'b1;
        end
    end

    // stage 6: corrected OFF and SENS
    logic [23:0]        r6_d1;
    logic signed [39:0] r6_offc, r6_sensc;
    logic signed [14:0] r6_temp;
    logic               r6_hit;
    logic signed [39:0] n6_offc, n6_sensc;

    assign n6_offc  = $signed({{4{r5_off[35]}}, r5_off}) - $signed({2'b0, r5_off2});
    assign n6_sensc = $signed({{4{r5_sens[35]}}, r5_sens}) - $signed({2'b0, r5_sens2});

    // stage 7: partial products of D1 * SENS
    logic [43:0]        r7_pl;
    logic signed [44:0] r7_ph;
    logic signed [39:0] r7_offc;
    logic signed [14:0] r7_temp;
    logic               r7_hit;
    logic [43:0]        n7_pl;
    logic signed [44:0] n7_ph;

    assign n7_pl = {20'b0, r6_d1} * {24'b0, r6_sensc[19:0]};
    assign n7_ph = $signed({1'b0, r6_d1}) * $signed(r6_sensc[39:20]);

    // stage 8: full product
    logic signed [63:0] r8_prod;
    logic signed [39:0] r8_offc;
    logic signed [14:0] r8_temp;
    logic               r8_hit;
    logic signed [63:0] n8_prod;

    assign n8_prod = ($signed({{19{r7_ph[44]}}, r7_ph}) <<< 20) + $signed({20'b0, r7_pl});

    // stage 9: scale by 2^21 and remove offset
    logic signed [43:0] r9_x;
    logic signed [14:0] r9_temp;
    logic               r9_hit;
    logic signed [63:0] n9_q;
    logic signed [43:0] n9_x;

    assign n9_q = (r8_prod + (r8_prod[63] ? 64'sd2097151 : 64'sd0)) >>> 21;
    assign n9_x = $signed({n9_q[42], n9_q[42:0]}) - $signed({{4{r8_offc[39]}}, r8_offc});

    // stage 10: scale by 2^15, clamp, output register
    logic signed [14:0] r10_temp;
    logic [16:0]        r10_pres;
    logic               r10_clip;
    logic signed [43:0] n10_q;
    logic signed [28:0] n10_p;
    logic signed [28:0] n10_pc;
    logic               n10_hit;

    assign n10_q = (r9_x + (r9_x[43] ? 44'sd32767 : 44'sd0)) >>> 15;
    assign n10_p = n10_q[28:0];

    always_comb begin
        n10_pc  = n10_p;
        n10_hit = 1'b0;
        if (n10_p < bsoc_pkg::PRES_MIN) begin
            n10_pc  = bsoc_pkg::PRES_MIN;
            n10_hit = 1'b1;
        end else if (n10_p > bsoc_pkg::PRES_MAX) begin
            n10_pc  = bsoc_pkg::PRES_MAX;
            n10_hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_d1 <= i_pressure_raw;
            r1_dt <= n1_dt;
        end
        if (en[1]) begin
            r2_d1  <= r1_d1;
            r2_pt  <= n2_pt;
            r2_po  <= n2_po;
            r2_ps  <= n2_ps;
            r2_pdd <= n2_pdd[47:0];
        end
        if (en[2]) begin
            r3_d1   <= r2_d1;
            r3_temp <= n3_temp;
            r3_off  <= n3_off;
            r3_sens <= n3_sens;
            r3_t2   <= r2_pdd[47:31];
        end
        if (en[3]) begin
            r4_d1      <= r3_d1;
            r4_temp    <= r3_temp;
            r4_off     <= r3_off;
            r4_sens    <= r3_sens;
            r4_t2      <= r3_t2;
            r4_sqa     <= n4_sqa[35:0];
            r4_sqb     <= n4_sqb[35:0];
            r4_lt_ref  <= (r3_temp < bsoc_pkg::TEMP_REF);
            r4_lt_cold <= (r3_temp < bsoc_pkg::TEMP_COLD);
        end
        if (en[4]) begin
            r5_d1    <= r4_d1;
            r5_off   <= r4_off;
            r5_sens  <= r4_sens;
            r5_off2  <= n5_off2[37:0];
            r5_sens2 <= n5_sens2[37:0];
            r5_temp  <= n5_tc[14:0];
            r5_hit   <= n5_hit;
        end
        if (en[5]) begin
            r6_d1    <= r5_d1;
            r6_offc  <= n6_offc;
            r6_sensc <= n6_sensc;
            r6_temp  <= r5_temp;
            r6_hit   <= r5_hit;
        end
        if (en[6]) begin
            r7_pl   <= n7_pl;
            r7_ph   <= n7_ph;
            r7_offc <= r6_offc;
            r7_temp <= r6_temp;
            r7_hit  <= r6_hit;
        end
        if (en[7]) begin
            r8_prod <= n8_prod;
            r8_offc <= r7_offc;
            r8_temp <= r7_temp;
            r8_hit  <= r7_hit;
        end
        if (en[8]) begin
            r9_x    <= n9_x;
            r9_temp <= r8_temp;
            r9_hit  <= r8_hit;
        end
        if (en[9]) begin
            r10_temp <= r9_temp;
            r10_pres <= n10_pc[16:0];
            r10_clip <= r9_hit | n10_hit;
        end
    end

    assign o_temperature_centi = r10_temp;
    assign o_pressure_pa       = r10_pres;
    assign o_clipped           = r10_clip;

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for barometer_second_order_compensation: a directed table, then
// random calibration phases, every result checked against a table value or a local compensation model.
// Depends on bsoc_pkg and the block's RTL; needs no files or arguments.

module tb_top;

    localparam longint SCALE_7  = 64'sd1 <<< 7;
    localparam longint SCALE_8  = 64'sd1 <<< 8;
    localparam longint SCALE_15 = 64'sd1 <<< 15;
    localparam longint SCALE_16 = 64'sd1 <<< 16;
    localparam longint SCALE_21 = 64'sd1 <<< 21;
    localparam longint SCALE_23 = 64'sd1 <<< 23;
    localparam longint SCALE_31 = 64'sd1 <<< 31;

    localparam logic [2:0] CFG_NONE_LO = 3'd6;
    localparam logic [2:0] CFG_NONE_HI = 3'd7;

    localparam int PHASES     = 6;
    localparam int PHASE_REQS = 125;
    localparam int LONG_HOLD  = 80;

    localparam logic [15:0] TYP_CAL [6] = '{16'd40127, 16'd36924, 16'd23317,
                                            16'd23282, 16'd33464, 16'd28312};

    typedef enum logic { ROW_READ, ROW_CFG } t_row_kind;
    typedef enum { CAL_TYPICAL, CAL_RANDOM, CAL_EXTREME } t_cal_style;

    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic [16:0]        pres_pa;
        logic               clip;
    } t_comp_result;

    typedef struct packed {
        t_row_kind          kind;
        logic [2:0]         idx;
        logic [15:0]        data;
        logic [23:0]        d1;
        logic [23:0]        d2;
        logic               typed;
        logic signed [14:0] w_temp;
        logic [16:0]        w_pres;
        logic               w_clip;
    } t_stim_row;

    localparam int DIR_ROWS = 31;
    t_stim_row dir_table [DIR_ROWS] = '{
        // zero calibration after reset
        '{ROW_READ, 3'd0, 16'h0000, 24'h000000, 24'h000000, 1'b1, 15'sd2000, 17'd1000, 1'b1},
        '{ROW_READ, 3'd0, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 15'sd2000, 17'd1000, 1'b1},
        '{ROW_READ, 3'd0, 16'h0000, 24'hAAAAAA, 24'h555555, 1'b1, 15'sd2000, 17'd1000, 1'b1},
        // unknown register indexes are ignored
        '{ROW_CFG, CFG_NONE_LO, 16'hFFFF, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, CFG_NONE_HI, 16'h1234, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'h555555, 24'hAAAAAA, 1'b1, 15'sd2000, 17'd1000, 1'b1},
        // typical calibration
        '{ROW_CFG, bsoc_pkg::CFG_SENS,        16'd40127, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_OFFSET,      16'd36924, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_SENS_TEMP,   16'd23317, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_OFFSET_TEMP, 16'd23282, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_REF_TEMP,    16'd33464, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_TEMP_SLOPE,  16'd28312, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'd9085466, 24'd8569150, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'd0,       24'd8569150, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'hFFFFFF,  24'd8569150, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'd9085466, 24'd0,       1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'd9085466, 24'hFFFFFF,  1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'd9085466, 24'd7800000, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'd9085466, 24'd7200000, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'd9085466, 24'd8400000, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'd9085466, 24'd10000000, 1'b0, 15'sd0, 17'd0, 1'b0},
        // all-ones calibration
        '{ROW_CFG, bsoc_pkg::CFG_SENS,        16'hFFFF, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_OFFSET,      16'hFFFF, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_SENS_TEMP,   16'hFFFF, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_OFFSET_TEMP, 16'hFFFF, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_REF_TEMP,    16'hFFFF, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_CFG, bsoc_pkg::CFG_TEMP_SLOPE,  16'hFFFF, 24'd0, 24'd0, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'h000000, 24'h000000, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'h800000, 24'hFFFF00, 1'b0, 15'sd0, 17'd0, 1'b0},
        '{ROW_READ, 3'd0, 16'h0000, 24'hFFFFFF, 24'h000000, 1'b0, 15'sd0, 17'd0, 1'b0}
    };

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_valid           = 1'b0;
    logic [23:0]        i_pressure_raw    = '0;
    logic [23:0]        i_temperature_raw = '0;
    logic               i_stall           = 1'b0;
    logic               i_cfg_valid       = 1'b0;
    logic [2:0]         i_cfg_index       = '0;
    logic [15:0]        i_cfg_data        = '0;
    logic               o_stall;
    logic               o_valid;
    logic signed [14:0] o_temperature_centi;
    logic [16:0]        o_pressure_pa;
    logic               o_clipped;
    logic               o_cfg_ready;

    logic [15:0]  cal [6] = '{default: 16'h0000};
    t_comp_result pending [$];

    logic send_gaps = 1'b1;
    logic recv_gaps = 1'b1;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;

    int n_errors = 0;
    int n_readings = 0;
    int n_writes = 0;
    int n_checked = 0;
    int n_clipped = 0;
    int n_cold = 0;
    int n_backpressure = 0;

    barometer_second_order_compensation u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_pressure_raw     (i_pressure_raw),
        .i_temperature_raw  (i_temperature_raw),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_temperature_centi(o_temperature_centi),
        .o_pressure_pa      (o_pressure_pa),
        .o_clipped          (o_clipped),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_comp_result compensate(input logic [23:0] d1_raw,
                                                input logic [23:0] d2_raw);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, t2, off2, sens2, sq, p;
        t_comp_result r;
        d1 = d1_raw;
        d2 = d2_raw;
        c1 = cal[bsoc_pkg::CFG_SENS];
        c2 = cal[bsoc_pkg::CFG_OFFSET];
        c3 = cal[bsoc_pkg::CFG_SENS_TEMP];
        c4 = cal[bsoc_pkg::CFG_OFFSET_TEMP];
        c5 = cal[bsoc_pkg::CFG_REF_TEMP];
        c6 = cal[bsoc_pkg::CFG_TEMP_SLOPE];
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        dt   = d2 - c5 * SCALE_8;
        temp = bsoc_pkg::TEMP_REF + dt * c6 / SCALE_23;
        off  = c2 * SCALE_16 + dt * c4 / SCALE_7;
        sens = c1 * SCALE_15 + dt * c3 / SCALE_8;
        // second-order terms use the first-order temperature
        if (temp < bsoc_pkg::TEMP_REF) begin
            t2    = dt * dt / SCALE_31;
            sq    = (temp - bsoc_pkg::TEMP_REF) * (temp - bsoc_pkg::TEMP_REF);
            off2  = 5 * sq / 2;
            sens2 = 5 * sq / 4;
            if (temp < bsoc_pkg::TEMP_COLD) begin
                sq    = (temp - bsoc_pkg::TEMP_COLD) * (temp - bsoc_pkg::TEMP_COLD);
                off2  = off2 + 7 * sq;
                sens2 = sens2 + 11 * sq / 2;
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p = (d1 * sens / SCALE_21 - off) / SCALE_15;
        r.clip = 1'b0;
        if (temp < bsoc_pkg::TEMP_MIN) begin
            temp = bsoc_pkg::TEMP_MIN;
            r.clip = 1'b1;
        end else if (temp > bsoc_pkg::TEMP_MAX) begin
            temp = bsoc_pkg::TEMP_MAX;
            r.clip = 1'b1;
        end
        if (p < bsoc_pkg::PRES_MIN) begin
            p = bsoc_pkg::PRES_MIN;
            r.clip = 1'b1;
        end else if (p > bsoc_pkg::PRES_MAX) begin
            p = bsoc_pkg::PRES_MAX;
            r.clip = 1'b1;
        end
        r.temp_centi = temp[14:0];
        r.pres_pa    = p[16:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // mostly readings around the calibrated operating point, some full-range noise
    function automatic logic [23:0] pick_temp_raw();
        int v;
        if ($urandom_range(99) < 25)
            return 24'($urandom);
        v = int'(cal[bsoc_pkg::CFG_REF_TEMP]) * 256 + int'($urandom_range(5_000_000))
            - 2_500_000;
        if (v < 0)
            v = 0;
        else if (v > 24'hFFFFFF)
            v = 24'hFFFFFF;
        return v[23:0];
    endfunction

    function automatic logic [23:0] pick_pres_raw();
        if ($urandom_range(99) < 25)
            return 24'($urandom);
        return 24'($urandom_range(11_000_000, 5_000_000));
    endfunction

    task automatic push_reading(input logic [23:0] d1, input logic [23:0] d2,
                                input logic typed, input t_comp_result typed_want);
        while (send_gaps && $urandom_range(99) < 22) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_pressure_raw    <= d1;
        i_temperature_raw <= d2;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending.push_back(typed ? typed_want : compensate(d1, d2));
        n_readings++;
        @(negedge i_clk);
    endtask

    task automatic write_cal(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx <= bsoc_pkg::CFG_TEMP_SLOPE)
            cal[idx] = data;
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending.size() != 0)
            @(negedge i_clk);
        repeat (bsoc_pkg::NUM_STAGES + 2) @(negedge i_clk);
    endtask

    task automatic load_cal(input t_cal_style style);
        logic [15:0] v;
        wait_idle();
        for (int i = 0; i < 6; i++) begin
            case (style)
                CAL_TYPICAL: v = TYP_CAL[i] + 16'($urandom_range(4000)) - 16'd2000;
                CAL_RANDOM:  v = 16'($urandom);
                default: begin
                    case ($urandom_range(2))
                        0:       v = 16'h0000;
                        1:       v = 16'hFFFF;
                        default: v = 16'($urandom);
                    endcase
                end
            endcase
            write_cal(3'(i), v);
        end
        if ($urandom_range(1))
            write_cal($urandom_range(1) ? CFG_NONE_HI : CFG_NONE_LO, 16'($urandom));
    endtask

    // receiver: random stall, plus a long hold when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= recv_gaps && ($urandom_range(99) < 22);
        end
    end

    always @(posedge i_clk) begin
        t_comp_result want;
        if (i_rst_n && i_valid && o_stall)
            n_backpressure++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = pending.pop_front();
                n_checked++;
                if (want.clip)
                    n_clipped++;
                if (want.temp_centi < bsoc_pkg::TEMP_REF)
                    n_cold++;
                if (o_temperature_centi !== want.temp_centi)
                    report_mismatch($sformatf("temperature_centi %0d, expected %0d",
                                              o_temperature_centi, want.temp_centi));
                if (o_pressure_pa !== want.pres_pa)
                    report_mismatch($sformatf("pressure_pa %0d, expected %0d",
                                              o_pressure_pa, want.pres_pa));
                if (o_clipped !== want.clip)
                    report_mismatch($sformatf("clipped %b, expected %b",
                                              o_clipped, want.clip));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_comp_result want;
        int           spin;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_CFG) begin
                wait_idle();
                write_cal(dir_table[r].idx, dir_table[r].data);
            end else begin
                want.temp_centi = dir_table[r].w_temp;
                want.pres_pa    = dir_table[r].w_pres;
                want.clip       = dir_table[r].w_clip;
                push_reading(dir_table[r].d1, dir_table[r].d2, dir_table[r].typed, want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1:       load_cal(CAL_RANDOM);
                4:       load_cal(CAL_EXTREME);
                default: load_cal(CAL_TYPICAL);
            endcase
            send_gaps = (ph != 2);
            recv_gaps = (ph != 2);
            for (int k = 0; k < PHASE_REQS; k++) begin
                if (ph == 3 && k == 20)
                    hold_requests++;
                push_reading(pick_pres_raw(), pick_temp_raw(), 1'b0, '0);
            end
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        i_valid <= 1'b0;

        spin = 0;
        while (pending.size() != 0 && spin < 5000) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (bsoc_pkg::NUM_STAGES + 10) @(posedge i_clk);
        if (pending.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", pending.size()));

        $display("Sent %0d readings and %0d calibration writes over %0d random phases.",
                 n_readings, n_writes, PHASES);
        $display("Checked %0d results: %0d saturated, %0d below 20 C, %0d input stalls.",
                 n_checked, n_clipped, n_cold, n_backpressure);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[barometer_second_order_compensation.f]
rtl/bsoc_pkg.sv
rtl/barometer_second_order_compensation.sv
bench/tb_top.sv
